// ===== sv/urw_pkg.sv =====
// Package for the ultrametric random walk step block.
// Holds generator constants, opcodes, register indexes, state types and result structs.
// No dependencies.
package urw_pkg;

  localparam int MAX_DIGITS_DEF = 64;

  localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_ONE    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_TWO    = 64'h94D049BB133111EB;
  localparam int SHIFT_A = 30;
  localparam int SHIFT_B = 27;
  localparam int SHIFT_C = 31;
  localparam int U_SHIFT = 11;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_STEP    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_DEPTH = 2'd1;
  localparam logic [1:0] REG_SEED  = 2'd2;
  localparam logic [1:0] REG_START = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_RS_GO, S_DRAW, S_DRAW_W, S_DIV_W, S_SRCH_RD, S_SRCH_CMP,
    S_UPD_RD, S_UPD_GO, S_HI_CHK, S_SITE_RD, S_SITE_ACC, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    K_U, K_DELTA, K_UPD, K_HI, K_RS
  } kind_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } mix_res_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [7:0]  rem;
  } div_res_t;

endpackage

// ===== sv/urw_mix.sv =====
// Generator output mixer: two 64-bit multiplies, each built from three
// 32x32 partial products. Depends on urw_pkg.
module urw_mix (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      z,
  output urw_pkg::mix_res_t res
);
  import urw_pkg::*;

  logic        busy;
  logic        round;
  logic [1:0]  ph;
  logic [63:0] a;
  logic [63:0] acc;
  logic [63:0] acc_next;
  logic [63:0] b;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] prod;

  assign b = round ? MIX_TWO : MIX_ONE;

  always_comb begin
    case (ph)
      2'd0: begin
        ma = a[31:0];
        mb = b[31:0];
      end
      2'd1: begin
        ma = a[31:0];
        mb = b[63:32];
      end
      default: begin
        ma = a[63:32];
        mb = b[31:0];
      end
    endcase
    prod = ma * mb;
    if (ph == 2'd0) begin
      acc_next = acc + prod;
    end else begin
      acc_next = acc + {prod[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      round    <= 1'b0;
      ph       <= 2'd0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        round <= 1'b0;
        ph    <= 2'd0;
      end else if (busy) begin
        if (ph == 2'd2) begin
          ph <= 2'd0;
          if (round) begin
            busy     <= 1'b0;
            res.done <= 1'b1;
          end
          round <= 1'b1;
        end else begin
          ph <= ph + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a   <= z ^ (z >> SHIFT_A);
      acc <= 64'd0;
    end else if (busy) begin
      if (ph == 2'd2) begin
        acc <= 64'd0;
        if (round) begin
          res.value <= acc_next ^ (acc_next >> SHIFT_C);
        end else begin
          a <= acc_next ^ (acc_next >> SHIFT_B);
        end
      end else begin
        acc <= acc_next;
      end
    end
  end

endmodule

// ===== sv/urw_div.sv =====
// Restoring divider: 64-bit dividend by 8-bit divisor, one quotient bit
// per cycle. Depends on urw_pkg.
module urw_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      dividend,
  input  logic [7:0]       divisor,
  output urw_pkg::div_res_t res
);
  import urw_pkg::*;

  logic       busy;
  logic [6:0] cnt;
  logic [7:0] d;
  logic [8:0] rr;
  logic       ge;

  assign rr = {res.rem, res.quo[63]};
  assign ge = rr >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= 7'd0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy     <= 1'b0;
          res.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      res.quo <= dividend;
      res.rem <= 8'd0;
      d       <= divisor;
    end else if (busy) begin
      if (ge) begin
        res.rem <= 8'(rr - {1'b0, d});
      end else begin
        res.rem <= rr[7:0];
      end
      res.quo <= {res.quo[62:0], ge};
    end
  end

endmodule

// ===== sv/ultrametric_random_walk_step.sv =====
// Top level of the ultrametric random walk step block: sequencer, digit
// and threshold memories. Depends on urw_pkg, urw_mix and urw_div.
//
// Configuration writes (base, depth_digits, seed, start_site) go in through
// cfg_write, cfg_index and cfg_data; the user must make them only while the
// block is idle, as the block itself does not enforce it. Requests arrive on
// the in_valid/in_ready channel; in_ready is high only while the sequencer
// is idle. A threshold load is written as it is accepted and leaves the
// sequencer idle. A restart runs one pass of the bit-serial divider per
// digit, over n digits. A step draws u in the mixer, scans shells through
// the threshold memory, draws and divides for the delta, divides again for
// the changed digit, then draws and divides for each digit above it, and
// last rebuilds the site over n digits. A step's result lands in an output
// register; the sequencer waits only if the previous result has not been
// taken yet. Reset clears generator state and digits and restores register
// defaults; thresholds hold nothing until loaded.
module ultrametric_random_walk_step #(
  parameter int MAX_DIGITS = urw_pkg::MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [6:0]  table_index,
  input  logic [53:0] threshold_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] site,
  output logic [6:0]  separation
);
  import urw_pkg::*;

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [7:0]  base;
  logic [6:0]  depth_digits;
  logic [63:0] seed;
  logic [63:0] start_site;

  state_t state, state_next;
  kind_t  kind;

  logic [63:0]   gen;
  logic [52:0]   u;
  logic [CW-1:0] t;
  logic [CW-1:0] s;
  logic [CW-1:0] d;
  logic [CW-1:0] i;
  logic [7:0]    delta;
  logic [63:0]   v;
  logic [63:0]   acc_site;

  logic [53:0] thr_mem [MAX_DIGITS];
  logic [7:0]  dig_mem [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] dig_vld;
  logic [53:0] thr_q;
  logic [7:0]  dig_q;
  logic        vld_q;
  logic [7:0]  dig_val;

  logic [7:0]    p;
  logic [CW-1:0] n;
  logic [CW-1:0] t_m1;
  logic [CW-1:0] i_m1;
  logic [AW-1:0] thr_raddr;
  logic [AW-1:0] dig_raddr;
  logic          dig_we;
  logic [AW-1:0] dig_waddr;
  logic [6:0]    tix;
  logic          accept;
  logic          hit;
  logic [71:0]   site_mul;

  logic        mix_start;
  logic [63:0] mix_z;
  mix_res_t    mix_res;
  logic        div_start;
  logic [63:0] div_dividend;
  logic [7:0]  div_divisor;
  div_res_t    div_res;

  urw_mix u_mix (
    .clk   (clk),
    .rst   (rst),
    .start (mix_start),
    .z     (mix_z),
    .res   (mix_res)
  );

  urw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  assign p = (base < 8'd2) ? 8'd2 : base;
  assign n = (depth_digits == 7'd0) ? CW'(1) :
             (depth_digits > 7'(MAX_DIGITS)) ? CW'(MAX_DIGITS) : CW'(depth_digits);
  assign t_m1 = t - CW'(1);
  assign i_m1 = i - CW'(1);
  assign thr_raddr = t_m1[AW-1:0];
  assign dig_raddr = (state == S_UPD_RD) ? d[AW-1:0] : i_m1[AW-1:0];
  assign dig_val = vld_q ? dig_q : 8'd0;
  assign tix = table_index - 7'd1;
  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign hit = ({1'b0, u} <= thr_q) || (t == n);
  assign mix_z = gen + GOLDEN_INC;
  assign mix_start = (state == S_DRAW);
  assign site_mul = acc_site * p;
  assign dig_waddr = (kind == K_UPD) ? d[AW-1:0] : i[AW-1:0];
  assign dig_we = (state == S_DIV_W) && div_res.done && (kind != K_DELTA);

  always_ff @(posedge clk) begin
    if (rst) begin
      base         <= 8'd2;
      depth_digits <= 7'd1;
      seed         <= 64'd0;
      start_site   <= 64'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE:  base         <= cfg_data[7:0];
        REG_DEPTH: depth_digits <= cfg_data[6:0];
        REG_SEED:  seed         <= cfg_data;
        REG_START: start_site   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_LOAD && table_index != 7'd0 &&
        table_index <= 7'(MAX_DIGITS)) begin
      thr_mem[tix[AW-1:0]] <= threshold_value;
    end
    thr_q <= thr_mem[thr_raddr];
  end

  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_mem[dig_waddr] <= div_res.rem;
    end
    dig_q <= dig_mem[dig_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dig_vld <= '0;
      vld_q   <= 1'b0;
    end else begin
      vld_q <= dig_vld[dig_raddr];
      if (accept && opcode == OP_RESTART) begin
        dig_vld <= '0;
      end else if (dig_we) begin
        dig_vld[dig_waddr] <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = mix_res.value;
    div_divisor  = p;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_RESTART) begin
            state_next = S_RS_GO;
          end else if (opcode == OP_STEP) begin
            state_next = S_DRAW;
          end
        end
      end
      S_RS_GO: begin
        div_start    = 1'b1;
        div_dividend = v;
        state_next   = S_DIV_W;
      end
      S_DRAW: state_next = S_DRAW_W;
      S_DRAW_W: begin
        if (mix_res.done) begin
          if (kind == K_U) begin
            state_next = S_SRCH_RD;
          end else begin
            div_start = 1'b1;
            if (kind == K_DELTA) begin
              div_divisor = p - 8'd1;
            end
            state_next = S_DIV_W;
          end
        end
      end
      S_DIV_W: begin
        if (div_res.done) begin
          case (kind)
            K_RS:    state_next = (i + CW'(1) == n) ? S_IDLE : S_RS_GO;
            K_DELTA: state_next = S_UPD_RD;
            default: state_next = S_HI_CHK;
          endcase
        end
      end
      S_SRCH_RD: state_next = S_SRCH_CMP;
      S_SRCH_CMP: state_next = hit ? S_DRAW : S_SRCH_RD;
      S_UPD_RD: state_next = S_UPD_GO;
      S_UPD_GO: begin
        div_start    = 1'b1;
        div_dividend = {55'd0, {1'b0, dig_val} + {1'b0, delta}};
        state_next   = S_DIV_W;
      end
      S_HI_CHK: state_next = (i >= n) ? S_SITE_RD : S_DRAW;
      S_SITE_RD: state_next = S_SITE_ACC;
      S_SITE_ACC: state_next = (i == CW'(1)) ? S_OUT : S_SITE_RD;
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gen       <= 64'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept && opcode == OP_RESTART) begin
        gen <= seed;
      end
      if (state == S_DRAW) begin
        gen <= mix_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          kind <= (opcode == OP_RESTART) ? K_RS : K_U;
          v    <= start_site;
          i    <= '0;
        end
      end
      S_DRAW_W: begin
        if (mix_res.done && kind == K_U) begin
          u <= mix_res.value[63:U_SHIFT];
          t <= CW'(1);
        end
      end
      S_SRCH_CMP: begin
        if (hit) begin
          s    <= t;
          d    <= n - t;
          kind <= K_DELTA;
        end else begin
          t <= t + CW'(1);
        end
      end
      S_DIV_W: begin
        if (div_res.done) begin
          case (kind)
            K_RS: begin
              v <= div_res.quo;
              i <= i + CW'(1);
            end
            K_DELTA: begin
              delta <= div_res.rem + 8'd1;
              kind  <= K_UPD;
            end
            K_UPD: i <= d + CW'(1);
            default: i <= i + CW'(1);
          endcase
        end
      end
      S_HI_CHK: begin
        if (i >= n) begin
          i        <= n;
          acc_site <= 64'd0;
        end else begin
          kind <= K_HI;
        end
      end
      S_SITE_ACC: begin
        acc_site <= site_mul[63:0] + {56'd0, dig_val};
        i        <= i - CW'(1);
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          site       <= acc_site;
          separation <= 7'(s);
        end
      end
      default: ;
    endcase
  end

endmodule
